// ===== rtl/bpng_pkg.sv =====
// Shared constants, register indexes, state encoding and command/status types
// for the block peak noise gate. No dependencies.
package bpng_pkg;

    // Block and word sizes
    localparam int BLOCK_LEN      = 64;
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
    localparam int COEF_BITS      = GAIN_FRAC_BITS;
    localparam int ADDR_BITS      = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int STORE_BITS     = 2 * SAMPLE_BITS;

    // Gain step product: signed difference times zero-extended coefficient
    localparam int DIFF_BITS      = GAIN_BITS + 1;
    localparam int STEP_BITS      = DIFF_BITS + COEF_BITS + 1;
    // Sample times zero-extended gain
    localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;

    // Configuration port
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = SAMPLE_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BYPASS    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEREO    = 3'd5;

    // Unity gain and reset values
    localparam logic [GAIN_BITS-1:0]   GAIN_ONE      = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] RST_THRESHOLD = SAMPLE_BITS'(83886);
    localparam logic [GAIN_BITS-1:0]   RST_FLOOR     = GAIN_BITS'(66);
    localparam logic [COEF_BITS-1:0]   RST_ATTACK    = COEF_BITS'(57345);
    localparam logic [COEF_BITS-1:0]   RST_RELEASE   = COEF_BITS'(64668);

    localparam logic [ADDR_BITS-1:0]   LAST_IDX      = ADDR_BITS'(BLOCK_LEN - 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // Controller states
    typedef enum logic [2:0] {
        S_FILL,
        S_GAIN_MUL,
        S_GAIN_UPD,
        S_READ,
        S_MUL,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic store;     // write the accepted request into the block store
        logic step_mul;  // form the gain step product, latch mode bits
        logic gain_upd;  // apply the gain step, restart the block
        logic rd_en;     // read one stored entry
        logic mul_en;    // scale the entry just read
        logic out_next;  // result taken, move to the next entry
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic fill_last; // write slot is the final one of the block
        logic rd_last;   // read slot is the final one of the block
    } t_dp_stat;

endpackage

// ===== rtl/bpng_in_if.sv =====
// Input channel: one stereo sample pair per request.
// Depends on bpng_pkg.
interface bpng_in_if;
    logic               valid;
    logic               ready;
    bpng_pkg::t_sample  left_sample;
    bpng_pkg::t_sample  right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== rtl/bpng_out_if.sv =====
// Output channel: one gated stereo sample pair per request, with end-of-block flag.
// Depends on bpng_pkg.
interface bpng_out_if;
    logic               valid;
    logic               ready;
    bpng_pkg::t_sample  left_out;
    bpng_pkg::t_sample  right_out;
    logic               last_of_block;

    modport source (output valid, output left_out, output right_out,
                    output last_of_block, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input last_of_block, output ready);
endinterface

// ===== rtl/bpng_ctrl.sv =====
// Sequencing state machine: block fill, gain update and block drain.
// Depends on bpng_pkg; drives the datapath through t_dp_cmd.
module bpng_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  bpng_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output bpng_pkg::t_dp_cmd   o_cmd
);
    import bpng_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FILL: begin
                if (i_in_valid && i_stat.fill_last) begin
                    n_state = S_GAIN_MUL;
                end
            end
            S_GAIN_MUL: n_state = S_GAIN_UPD;
            S_GAIN_UPD: n_state = S_READ;
            S_READ:     n_state = S_MUL;
            S_MUL:      n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = i_stat.rd_last ? S_FILL : S_READ;
                end
            end
            default:    n_state = S_FILL;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_cmd            = '0;
        case (r_state)
            S_FILL: begin
                o_in_ready   = 1'b1;
                o_cmd.store  = i_in_valid;
            end
            S_GAIN_MUL: o_cmd.step_mul = 1'b1;
            S_GAIN_UPD: o_cmd.gain_upd = 1'b1;
            S_READ:     o_cmd.rd_en    = 1'b1;
            S_MUL:      o_cmd.mul_en   = 1'b1;
            S_OUT: begin
                o_out_valid    = 1'b1;
                o_cmd.out_next = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // The input and output sides are never open together
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open in the same cycle");

    // A completed block always proceeds straight to the gain update
    a_fill_to_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && i_in_valid && i_stat.fill_last) |=> (r_state == S_GAIN_MUL)
        ##1 (r_state == S_GAIN_UPD))
        else $error("block completion did not start the gain update");

    // Taking the final result of a block reopens the input
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_stat.rd_last) |=> o_in_ready)
        else $error("input not reopened after the final result");

endmodule

// ===== rtl/bpng_dp.sv =====
// Datapath: configuration registers, block store, peak tracker, gain step
// and output scaling. Depends on bpng_pkg; steered by bpng_ctrl.
module bpng_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bpng_pkg::t_dp_cmd                       i_cmd,
    output bpng_pkg::t_dp_stat                      o_stat,
    input  logic                                    i_cfg_we,
    input  logic [bpng_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [bpng_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  bpng_pkg::t_sample                       i_left,
    input  bpng_pkg::t_sample                       i_right,
    output bpng_pkg::t_sample                       o_left,
    output bpng_pkg::t_sample                       o_right,
    output logic                                    o_last
);
    import bpng_pkg::*;

    // Configuration registers
    logic [SAMPLE_BITS-1:0] r_threshold;
    logic [GAIN_BITS-1:0]   r_floor;
    logic [COEF_BITS-1:0]   r_attack;
    logic [COEF_BITS-1:0]   r_release;
    logic                   r_bypass_cfg;
    logic                   r_stereo_cfg;

    // Block state
    logic [STORE_BITS-1:0]  r_mem [0:BLOCK_LEN-1];
    logic [ADDR_BITS-1:0]   r_fill;
    logic [ADDR_BITS-1:0]   r_rd_idx;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic [GAIN_BITS-1:0]   r_gain;
    logic                   r_bypass;
    logic                   r_stereo;

    // Gain step pipeline
    logic [GAIN_BITS-1:0]         r_target;
    logic signed [STEP_BITS-1:0]  r_step_prod;

    // Drain pipeline
    t_sample                      r_rd_l;
    t_sample                      r_rd_r;
    logic signed [PROD_BITS-1:0]  r_lprod;
    logic signed [PROD_BITS-1:0]  r_rprod;

    logic [SAMPLE_BITS-1:0] n_peak;
    logic [SAMPLE_BITS-1:0] mag_l;
    logic [SAMPLE_BITS-1:0] mag_r;
    logic [GAIN_BITS-1:0]   floor_lim;
    logic [GAIN_BITS-1:0]   target;
    logic [COEF_BITS-1:0]   coef;
    logic signed [DIFF_BITS-1:0]  diff;
    logic [STEP_BITS-1:0]         step_mag;
    logic [STEP_BITS-1:0]         step_q;
    logic signed [STEP_BITS-1:0]  step_trunc;
    logic signed [STEP_BITS-1:0]  step_sum;
    logic [GAIN_BITS-1:0]         n_gain;
    logic signed [GAIN_BITS:0]    gain_s;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= RST_THRESHOLD;
            r_floor      <= RST_FLOOR;
            r_attack     <= RST_ATTACK;
            r_release    <= RST_RELEASE;
            r_bypass_cfg <= 1'b0;
            r_stereo_cfg <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold  <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_FLOOR:     r_floor      <= i_cfg_data[GAIN_BITS-1:0];
                CFG_ATTACK:    r_attack     <= i_cfg_data[COEF_BITS-1:0];
                CFG_RELEASE:   r_release    <= i_cfg_data[COEF_BITS-1:0];
                CFG_BYPASS:    r_bypass_cfg <= i_cfg_data[0];
                CFG_STEREO:    r_stereo_cfg <= i_cfg_data[0];
                default:       r_bypass_cfg <= r_bypass_cfg;
            endcase
        end
    end

    // Magnitudes; the most negative sample maps to 2^(SAMPLE_BITS-1), which fits unsigned
    assign mag_l = i_left[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-i_left)  : SAMPLE_BITS'(i_left);
    assign mag_r = i_right[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_right) : SAMPLE_BITS'(i_right);

    // Running peak over the block, right channel only in stereo
    always_comb begin
        n_peak = r_peak;
        if (mag_l > n_peak) begin
            n_peak = mag_l;
        end
        if (r_stereo_cfg && (mag_r > n_peak)) begin
            n_peak = mag_r;
        end
    end

    // Block store write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_fill] <= {i_left, i_right};
        end
        if (i_cmd.rd_en) begin
            {r_rd_l, r_rd_r} <= r_mem[r_rd_idx];
        end
    end

    // Target gain and coefficient selection
    always_comb begin
        floor_lim = (r_floor > GAIN_ONE) ? GAIN_ONE : r_floor;
        target    = (r_peak > r_threshold) ? GAIN_ONE : floor_lim;
        coef      = (target > r_gain) ? r_attack : r_release;
        diff      = $signed({1'b0, r_gain}) - $signed({1'b0, target});
    end

    // Truncate the step toward zero, add to the target and saturate
    always_comb begin
        step_mag   = r_step_prod[STEP_BITS-1] ? STEP_BITS'(-r_step_prod)
                                              : STEP_BITS'(r_step_prod);
        step_q     = step_mag >> GAIN_FRAC_BITS;
        step_trunc = r_step_prod[STEP_BITS-1] ? -$signed(step_q) : $signed(step_q);
        step_sum   = $signed(STEP_BITS'(r_target)) + step_trunc;
        if (step_sum < 0) begin
            n_gain = '0;
        end else if (step_sum > $signed(STEP_BITS'(GAIN_ONE))) begin
            n_gain = GAIN_ONE;
        end else begin
            n_gain = step_sum[GAIN_BITS-1:0];
        end
    end

    assign gain_s = $signed({1'b0, r_gain});

    // Control-side registers: counters, peak, gain and latched modes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_rd_idx <= '0;
            r_peak   <= '0;
            r_gain   <= GAIN_ONE;
            r_bypass <= 1'b0;
            r_stereo <= 1'b1;
        end else begin
            if (i_cmd.store) begin
                r_fill <= r_fill + ADDR_BITS'(1);
                r_peak <= n_peak;
            end
            if (i_cmd.step_mul) begin
                r_bypass <= r_bypass_cfg;
                r_stereo <= r_stereo_cfg;
            end
            if (i_cmd.gain_upd) begin
                r_fill   <= '0;
                r_rd_idx <= '0;
                r_peak   <= '0;
                if (!r_bypass) begin
                    r_gain <= n_gain;
                end
            end
            if (i_cmd.out_next) begin
                r_rd_idx <= r_rd_idx + ADDR_BITS'(1);
            end
        end
    end

    // Gain step product and sample products, registered after each multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.step_mul) begin
            r_target    <= target;
            r_step_prod <= diff * $signed({1'b0, coef});
        end
        if (i_cmd.mul_en) begin
            r_lprod <= r_rd_l * gain_s;
            r_rprod <= r_rd_r * gain_s;
        end
    end

    // Result selection: floor shift of the product, raw in bypass, right muted in mono
    always_comb begin
        o_left  = r_bypass ? r_rd_l : r_lprod[GAIN_FRAC_BITS +: SAMPLE_BITS];
        o_right = r_bypass ? r_rd_r : r_rprod[GAIN_FRAC_BITS +: SAMPLE_BITS];
        if (!r_stereo) begin
            o_right = '0;
        end
        o_last  = (r_rd_idx == LAST_IDX);
    end

    assign o_stat.fill_last = (r_fill == LAST_IDX);
    assign o_stat.rd_last   = (r_rd_idx == LAST_IDX);

    // The gain stays within zero to unity
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= GAIN_ONE)
        else $error("gate gain above unity");

    // A gain update restarts the block with a clear peak and empty store
    a_block_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gain_upd |=> (r_peak == '0) && (r_fill == '0) && (r_rd_idx == '0))
        else $error("block not restarted after the gain update");

    // In bypass the gain is held across the update
    a_bypass_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.gain_upd && r_bypass) |=> $stable(r_gain))
        else $error("gain changed in bypass");

endmodule

// ===== rtl/block_peak_noise_gate_core.sv =====
// An input request that does not complete a block is taken at once, as the input
// is ready throughout the fill. The request that completes a block passes the gain
// step states, a store read and a multiply before its first result; each further
// result again takes a store read, multiply and output once the last is taken.
// Reset clears control, restores gain to unity and the register defaults; store
// contents stay undefined and are only read after being written.
module block_peak_noise_gate_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bpng_in_if.sink                             i_in,
    bpng_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [bpng_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [bpng_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import bpng_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    bpng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // Storage and arithmetic
    bpng_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_left     (i_in.left_sample),
        .i_right    (i_in.right_sample),
        .o_left     (o_out.left_out),
        .o_right    (o_out.right_out),
        .o_last     (o_out.last_of_block)
    );

endmodule

// ===== test/bpng_gate_checker.sv =====
// Watches the request, result and register channels of the block peak noise gate,
// predicts every gated block and compares it with what the core emits.
// Depends on bpng_pkg, bpng_in_if and bpng_out_if.
module bpng_gate_checker
    import bpng_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bpng_in_if                        i_in_mon,
    bpng_out_if                       i_out_mon,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNITY = longint'(1) << GAIN_FRAC_BITS;

    typedef struct {
        t_sample left_val;
        t_sample right_val;
        logic    last;
    } t_gated_pair;

    // Results still owed by the core, oldest first
    t_gated_pair gated_q[$];

    // Shadow of the block in progress
    t_sample                held_left [BLOCK_LEN];
    t_sample                held_right[BLOCK_LEN];
    int unsigned            fill_level = 0;
    logic [SAMPLE_BITS-1:0] running_peak = '0;
    logic [GAIN_BITS-1:0]   gate_gain = GAIN_ONE;

    // Shadow of the register file
    logic [SAMPLE_BITS-1:0] thr_level    = RST_THRESHOLD;
    logic [GAIN_BITS-1:0]   floor_gain   = RST_FLOOR;
    logic [COEF_BITS-1:0]   attack_coef  = RST_ATTACK;
    logic [COEF_BITS-1:0]   release_coef = RST_RELEASE;
    logic                   bypass_on    = 1'b0;
    logic                   stereo_on    = 1'b1;

    int mismatch_total = 0;

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_total < 100) begin
            $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_total++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] magnitude(input t_sample s);
        longint v;
        v = s;
        return (v < 0) ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
    endfunction

    // One one-pole step of the gain toward the open or closed target.
    // The product is truncated toward zero so the target is reached exactly.
    function automatic logic [GAIN_BITS-1:0] stepped_gain();
        longint floor_lim;
        longint target;
        longint coef;
        longint gain_now;
        longint g;
        floor_lim = floor_gain;
        if (floor_lim > UNITY) begin
            floor_lim = UNITY;
        end
        gain_now = gate_gain;
        target   = (running_peak > thr_level) ? UNITY : floor_lim;
        if (target > gain_now) begin
            coef = attack_coef;
        end else begin
            coef = release_coef;
        end
        g = target + ((gain_now - target) * coef) / UNITY;
        if (g < 0) begin
            g = 0;
        end
        if (g > UNITY) begin
            g = UNITY;
        end
        return GAIN_BITS'(g);
    endfunction

    // Sample times gain, rounded toward minus infinity.
    function automatic t_sample scaled(input t_sample s, input longint gain);
        longint p;
        p = s;
        p = p * gain;
        return t_sample'(p >>> GAIN_FRAC_BITS);
    endfunction

    // A full block: update the gain unless bypassed, then queue the whole block.
    task automatic emit_block();
        t_gated_pair res;
        longint      g;
        if (!bypass_on) begin
            gate_gain = stepped_gain();
        end
        g = gate_gain;
        for (int k = 0; k < BLOCK_LEN; k++) begin
            res.left_val  = bypass_on ? held_left[k]  : scaled(held_left[k], g);
            res.right_val = bypass_on ? held_right[k] : scaled(held_right[k], g);
            if (!stereo_on) begin
                res.right_val = '0;
            end
            res.last = (k == BLOCK_LEN - 1);
            gated_q.insert(gated_q.size(), res);
        end
        fill_level   = 0;
        running_peak = '0;
    endtask

    // An accepted request joins the block and may raise the peak.
    task automatic take_pair(input t_sample l, input t_sample r);
        held_left[fill_level]  = l;
        held_right[fill_level] = r;
        if (magnitude(l) > running_peak) begin
            running_peak = magnitude(l);
        end
        if (stereo_on && magnitude(r) > running_peak) begin
            running_peak = magnitude(r);
        end
        fill_level++;
        if (fill_level == BLOCK_LEN) begin
            emit_block();
        end
    endtask

    task automatic check_result();
        t_gated_pair want;
        if (gated_q.size() == 0) begin
            report_mismatch("unexpected result, left_out", i_out_mon.left_out, 0);
        end else begin
            want = gated_q.pop_front();
            if (i_out_mon.left_out !== want.left_val) begin
                report_mismatch("left_out", i_out_mon.left_out, want.left_val);
            end
            if (i_out_mon.right_out !== want.right_val) begin
                report_mismatch("right_out", i_out_mon.right_out, want.right_val);
            end
            if (i_out_mon.last_of_block !== want.last) begin
                report_mismatch("last_of_block", i_out_mon.last_of_block, want.last);
            end
        end
    endtask

    // Everything is sampled at the rising edge, as the core sees it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_level    = RST_THRESHOLD;
            floor_gain   = RST_FLOOR;
            attack_coef  = RST_ATTACK;
            release_coef = RST_RELEASE;
            bypass_on    = 1'b0;
            stereo_on    = 1'b1;
            fill_level   = 0;
            running_peak = '0;
            gate_gain    = GAIN_ONE;
            gated_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: thr_level    = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_FLOOR:     floor_gain   = i_cfg_data[GAIN_BITS-1:0];
                    CFG_ATTACK:    attack_coef  = i_cfg_data[COEF_BITS-1:0];
                    CFG_RELEASE:   release_coef = i_cfg_data[COEF_BITS-1:0];
                    CFG_BYPASS:    bypass_on    = i_cfg_data[0];
                    CFG_STEREO:    stereo_on    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                check_result();
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                take_pair(i_in_mon.left_sample, i_in_mon.right_sample);
            end
        end
        o_pending    <= gated_q.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ===== test/tb_block_peak_noise_gate_core.sv =====
// Top of the block peak noise gate testbench: clock, reset, sample requests,
// register writes and output back-pressure. Depends on bpng_pkg, both channel
// interfaces, the core and bpng_gate_checker, which does all the checking.
module tb_block_peak_noise_gate_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bpng_pkg::*;

    localparam int      RANDOM_ITEMS = 210;
    localparam t_sample SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                     i_clk;
    logic                     i_rst_n  = 1'b0;
    logic                     cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int fail_count;
    int pending_count;
    int sent_count = 0;
    bit hold_done  = 1'b0;

    bpng_in_if  in_ch();
    bpng_out_if out_ch();

    block_peak_noise_gate_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bpng_gate_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run length
    initial begin
        #200000;
        $display("simulation failed");
        $finish;
    end

    // Offers one stereo request, with random gaps outside the quiet stretch,
    // and returns at the edge where it is taken.
    task automatic send_pair(input t_sample left_val, input t_sample right_val);
        while (!(sent_count >= 140 && sent_count < 200) && $urandom_range(99) < 17) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.left_sample  <= left_val;
        in_ch.right_sample <= right_val;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        sent_count++;
    endtask

    // Stops offering, waits until every owed result has come, then lets the
    // core settle back into filling.
    task automatic end_phase();
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_count != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // The caller lowers the write enable once after the last write.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input longint unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_BITS'(value);
        @(posedge i_clk);
    endtask

    // New register settings for a phase; extremes are drawn often.
    task automatic pick_settings(input bit all_regs, input int amp_shift);
        int unsigned pick;
        if (all_regs || $urandom_range(1) == 0) begin
            pick = $urandom_range(5);
            case (pick)
                0: write_reg(CFG_THRESHOLD, 0);
                1: write_reg(CFG_THRESHOLD, 24'd8388608);
                2: write_reg(CFG_THRESHOLD, 24'hFFFFFF);
                3: write_reg(CFG_THRESHOLD, $urandom_range(24'hFFFFFF));
                default: write_reg(CFG_THRESHOLD,
                                   (longint'(1) << (23 - amp_shift)) - $urandom_range(1));
            endcase
        end
        if (all_regs || $urandom_range(1) == 0) begin
            pick = $urandom_range(5);
            case (pick)
                0: write_reg(CFG_FLOOR, 0);
                1: write_reg(CFG_FLOOR, 65535);
                2: write_reg(CFG_FLOOR, 65536);
                3: write_reg(CFG_FLOOR, 17'h1FFFF);
                default: write_reg(CFG_FLOOR, $urandom_range(65536));
            endcase
        end
        if (all_regs || $urandom_range(1) == 0) begin
            pick = $urandom_range(2);
            write_reg(CFG_ATTACK, (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(65535));
        end
        if (all_regs || $urandom_range(1) == 0) begin
            pick = $urandom_range(2);
            write_reg(CFG_RELEASE, (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(65535));
        end
        if (all_regs || $urandom_range(1) == 0) begin
            write_reg(CFG_BYPASS, ($urandom_range(3) == 0) ? 1 : 0);
        end
        if (all_regs || $urandom_range(1) == 0) begin
            write_reg(CFG_STEREO, ($urandom_range(2) == 0) ? 0 : 1);
        end
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off while requests keep
    // coming, and a quiet stretch with the sender.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && pending_count > 0 && in_ch.valid) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (sent_count >= 140 && sent_count < 200) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 17);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int      random_sent;
        int      phase_len;
        int      amp_shift;
        bit      first_phase;
        t_sample l;
        t_sample r;
        t_sample amp_min;

        in_ch.valid        <= 1'b0;
        in_ch.left_sample  <= '0;
        in_ch.right_sample <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset settings: field extremes and bit patterns
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair('0, '0);
        send_pair(-1, -1);
        send_pair(1, -1);
        send_pair(24'h555555, 24'hAAAAAA);
        send_pair(24'hAAAAAA, 24'h555555);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(83886, -83887);

        // Mono in the middle of a block: the right side must not count in the peak
        end_phase();
        write_reg(CFG_STEREO, 0);
        cfg_we <= 1'b0;
        send_pair(3, SAMPLE_MIN);
        send_pair(-7, SAMPLE_MAX);
        send_pair(SAMPLE_MAX, 24'h123456);
        send_pair(-83886, SAMPLE_MIN);
        send_pair(0, -1);
        send_pair(100, 24'h7F0000);
        end_phase();
        write_reg(CFG_STEREO, 1);
        cfg_we <= 1'b0;
        send_pair(SAMPLE_MIN, 0);
        send_pair(0, SAMPLE_MIN);
        send_pair(65536, -65536);
        send_pair(-65537, 65535);

        // Random phases, each under fresh settings and its own amplitude
        random_sent = 0;
        first_phase = 1'b1;
        while (random_sent < RANDOM_ITEMS) begin
            amp_shift = ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
            amp_min   = t_sample'(-(longint'(1) << (23 - amp_shift)));
            end_phase();
            pick_settings(first_phase, amp_shift);
            first_phase = 1'b0;
            phase_len = $urandom_range(24, 72);
            if (phase_len > RANDOM_ITEMS - random_sent) begin
                phase_len = RANDOM_ITEMS - random_sent;
            end
            repeat (phase_len) begin
                l = t_sample'($urandom) >>> amp_shift;
                r = t_sample'($urandom) >>> amp_shift;
                if ($urandom_range(15) == 0) begin
                    l = amp_min;
                end
                if ($urandom_range(15) == 0) begin
                    r = amp_min;
                end
                send_pair(l, r);
                random_sent++;
            end
        end
        end_phase();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bpng_pkg.sv
rtl/bpng_in_if.sv
rtl/bpng_out_if.sv
rtl/bpng_ctrl.sv
rtl/bpng_dp.sv
rtl/block_peak_noise_gate_core.sv
test/bpng_gate_checker.sv
test/tb_block_peak_noise_gate_core.sv
